/* hw/rtl/tlss_pkg.sv */
// Package for the two-level scheduler: operation, event and command codes,
// request and status types. No dependencies.
package tlss_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_CREATE = 2'd1,
        OP_EXIT   = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_CREATED  = 3'd1,
        EV_REFUSED  = 3'd2,
        EV_PREEMPT  = 3'd3,
        EV_EJECTED  = 3'd4,
        EV_FINISHED = 3'd5
    } t_event;

    typedef enum logic [3:0] {
        CMD_NOP        = 4'd0,
        CMD_SCAN_START = 4'd1,
        CMD_SCAN_STEP  = 4'd2,
        CMD_ALLOC      = 4'd3,
        CMD_TICK       = 4'd4,
        CMD_FREECUR    = 4'd5,
        CMD_SETINS     = 4'd6,
        CMD_RINGPUSH   = 4'd7,
        CMD_DISP       = 4'd8,
        CMD_DSHIFT     = 4'd9,
        CMD_DSHEND     = 4'd10,
        CMD_PTRSET     = 4'd11,
        CMD_INSSHIFT   = 4'd12,
        CMD_INSPUT     = 4'd13
    } t_cmd;

    typedef struct packed {
        logic free_found;
        logic scan_end;
        logic list_any;
        logic cur_valid;
        logic cur_high;
        logic cur_neg;
        logic slice_zero;
        logic ins_high;
        logic ins_stop;
        logic shift_done;
        logic dshift_end;
        logic head_shorter;
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic        priority_req;
        logic [15:0] budget_ticks;
    } t_in_req;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] created_id;
        logic [3:0] running_id;
        logic       running_valid;
    } t_out_req;

    localparam int unsigned QUANTUM_RESET = 16;

endpackage

/* hw/rtl/tlss_in_if.sv */
// Input request channel: valid, ready and the operation payload.
// Depends on tlss_pkg.
interface tlss_in_if;
    logic              valid;
    logic              ready;
    tlss_pkg::t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tlss_out_if.sv */
// Result request channel: valid, ready and the event payload.
// Depends on tlss_pkg.
interface tlss_out_if;
    logic               valid;
    logic               ready;
    tlss_pkg::t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tlss_cfg_if.sv */
// Configuration write channel carrying the quantum register.
// No dependencies.
interface tlss_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tlss_datapath.sv */
// Datapath: slot table, sorted list, ring, running thread and slice counter.
// Executes one command per cycle from tlss_ctrl. Depends on tlss_pkg.
module tlss_datapath #(
    parameter int MAX_THREADS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_quantum,
    input  tlss_pkg::t_in_req     i_req,
    input  tlss_pkg::t_cmd        i_cmd,
    output tlss_pkg::t_status     o_status,
    output logic [$clog2(MAX_THREADS)-1:0] o_created,
    output logic [$clog2(MAX_THREADS)-1:0] o_cur,
    output logic                  o_cur_valid
);
    import tlss_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = IW + 1;

    logic               r_busy [MAX_THREADS];
    logic               r_high [MAX_THREADS];
    logic signed [16:0] r_rem  [MAX_THREADS];
    logic [IW-1:0]      r_list [MAX_THREADS];
    logic [IW-1:0]      r_ring [MAX_THREADS];
    logic [CW-1:0]      r_lcnt, r_rcnt, r_idx, r_ptr;
    logic [IW-1:0]      r_rhead, r_cur, r_ins, r_newid;
    logic               r_cvalid;
    logic [7:0]         r_slice;

    logic [IW-1:0]      w_idx, w_ptr, w_tail, w_head_next;
    logic [CW:0]        w_tail_sum;
    logic signed [16:0] w_rem_cur;

    assign w_idx      = r_idx[IW-1:0];
    assign w_ptr      = r_ptr[IW-1:0];
    assign w_rem_cur  = r_rem[r_cur];
    assign w_tail_sum = (CW+1)'(r_rhead) + (CW+1)'(r_rcnt);
    assign w_tail     = (w_tail_sum >= (CW+1)'(MAX_THREADS)) ?
                        IW'(w_tail_sum - (CW+1)'(MAX_THREADS)) : IW'(w_tail_sum);
    assign w_head_next = (r_rhead == IW'(MAX_THREADS - 1)) ? '0 : r_rhead + 1'b1;

    always_comb begin
        o_status.free_found   = (r_idx < CW'(MAX_THREADS)) && !r_busy[w_idx];
        o_status.scan_end     = r_idx >= CW'(MAX_THREADS);
        o_status.list_any     = r_lcnt != '0;
        o_status.cur_valid    = r_cvalid;
        o_status.cur_high     = r_high[r_cur];
        o_status.cur_neg      = w_rem_cur[16];
        o_status.slice_zero   = r_slice == 8'd0;
        o_status.ins_high     = r_high[r_ins];
        o_status.ins_stop     = !((r_idx < r_lcnt) && (r_rem[r_list[w_idx]] <= r_rem[r_ins]));
        o_status.shift_done   = r_ptr == r_idx;
        o_status.dshift_end   = r_idx >= r_lcnt;
        o_status.head_shorter = r_rem[r_list[0]] < w_rem_cur;
    end
    assign o_created   = r_newid;
    assign o_cur       = r_cur;
    assign o_cur_valid = r_cvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_THREADS; k++) r_busy[k] <= 1'b0;
            r_lcnt <= '0; r_rcnt <= '0; r_rhead <= '0;
            r_cur <= '0; r_cvalid <= 1'b0; r_slice <= 8'd0;
            r_idx <= '0; r_ptr <= '0; r_ins <= '0; r_newid <= '0;
        end else begin
            case (i_cmd)
                CMD_SCAN_START: r_idx <= '0;
                CMD_SCAN_STEP:  r_idx <= r_idx + 1'b1;
                CMD_ALLOC: begin
                    r_busy[w_idx] <= 1'b1;
                    r_high[w_idx] <= i_req.priority_req;
                    r_rem[w_idx]  <= {1'b0, i_req.budget_ticks};
                    r_newid <= w_idx;
                    r_ins   <= w_idx;
                    r_idx   <= '0;
                end
                CMD_TICK: begin
                    r_rem[r_cur] <= w_rem_cur - 17'sd1;
                    if (r_slice != 8'd0) r_slice <= r_slice - 8'd1;
                end
                CMD_FREECUR: r_busy[r_cur] <= 1'b0;
                CMD_SETINS: begin
                    r_ins <= r_cur; r_idx <= '0;
                end
                CMD_RINGPUSH: begin
                    r_ring[w_tail] <= r_ins;
                    r_rcnt <= r_rcnt + 1'b1;
                end
                CMD_DISP: begin
                    r_slice <= i_quantum;
                    r_idx   <= CW'(1);
                    if (r_lcnt != '0) begin
                        r_cur <= r_list[0]; r_cvalid <= 1'b1;
                    end else if (r_rcnt != '0) begin
                        r_cur <= r_ring[r_rhead]; r_cvalid <= 1'b1;
                        r_rhead <= w_head_next; r_rcnt <= r_rcnt - 1'b1;
                    end else begin
                        r_cur <= '0; r_cvalid <= 1'b0;
                    end
                end
                CMD_DSHIFT: begin
                    r_list[IW'(r_idx - 1'b1)] <= r_list[w_idx];
                    r_idx <= r_idx + 1'b1;
                end
                CMD_DSHEND: begin
                    r_lcnt <= r_lcnt - 1'b1; r_idx <= '0;
                end
                CMD_PTRSET: r_ptr <= r_lcnt;
                CMD_INSSHIFT: begin
                    r_list[w_ptr] <= r_list[IW'(r_ptr - 1'b1)];
                    r_ptr <= r_ptr - 1'b1;
                end
                CMD_INSPUT: begin
                    r_list[w_idx] <= r_ins;
                    r_lcnt <= r_lcnt + 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

/* hw/rtl/tlss_ctrl.sv */
// Controller state machine sequencing the datapath for each request.
// Depends on tlss_pkg and drives tlss_datapath commands.
module tlss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tlss_pkg::t_in_req i_req,
    output tlss_pkg::t_in_req o_req,
    input  tlss_pkg::t_status i_status,
    output tlss_pkg::t_cmd    o_cmd,
    output logic              o_done,
    output tlss_pkg::t_event  o_event,
    input  logic              i_out_free
);
    import tlss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN, S_ENQ, S_TICKCHK, S_RINGPUSH, S_DISP,
        S_DSHIFT, S_INSSCAN, S_INSSHIFT, S_DONE
    } t_state;

    t_state        r_state, n_state;
    t_in_req       r_req;
    t_event        r_event, n_event;
    logic          r_reins, n_reins; // reinsert after dispatch
    t_cmd          w_cmd;

    assign o_req      = r_req;
    assign o_in_ready = r_state == S_IDLE;
    assign o_cmd      = w_cmd;
    assign o_done     = r_state == S_DONE && i_out_free;
    assign o_event    = r_event;

    always_comb begin
        n_state = r_state; n_event = r_event; n_reins = r_reins;
        w_cmd = CMD_NOP;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_state = S_DECODE; n_event = EV_NONE; n_reins = 1'b0;
            end
            S_DECODE: begin
                case (t_op'(r_req.op))
                    OP_TICK: begin
                        if (i_status.cur_valid) begin
                            w_cmd = CMD_TICK; n_state = S_TICKCHK;
                        end else n_state = S_DISP;
                    end
                    OP_CREATE: begin
                        w_cmd = CMD_SCAN_START; n_state = S_SCAN;
                    end
                    OP_EXIT: begin
                        if (i_status.cur_valid) begin
                            w_cmd = CMD_FREECUR; n_event = EV_FINISHED; n_state = S_DISP;
                        end else n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_event = EV_REFUSED; n_state = S_DONE;
                end else if (i_status.free_found) begin
                    w_cmd = CMD_ALLOC; n_event = EV_CREATED; n_state = S_ENQ;
                end else w_cmd = CMD_SCAN_STEP;
            end
            S_ENQ: n_state = i_status.ins_high ? S_INSSCAN : S_RINGPUSH;
            S_TICKCHK: begin
                if (i_status.cur_neg) begin
                    w_cmd = CMD_FREECUR; n_event = EV_EJECTED; n_state = S_DISP;
                end else if (i_status.cur_high) begin
                    if (i_status.list_any && i_status.head_shorter) begin
                        w_cmd = CMD_SETINS; n_event = EV_PREEMPT;
                        n_reins = 1'b1; n_state = S_DISP;
                    end else n_state = S_DONE;
                end else if (i_status.list_any || i_status.slice_zero) begin
                    w_cmd = CMD_SETINS; n_event = EV_PREEMPT; n_state = S_RINGPUSH;
                end else n_state = S_DONE;
            end
            S_RINGPUSH: begin
                w_cmd = CMD_RINGPUSH;
                n_state = (t_op'(r_req.op) == OP_CREATE) ? S_DONE : S_DISP;
            end
            S_DISP: begin
                w_cmd = CMD_DISP;
                n_state = i_status.list_any ? S_DSHIFT : S_DONE;
            end
            S_DSHIFT: begin
                if (!i_status.dshift_end) w_cmd = CMD_DSHIFT;
                else begin
                    w_cmd = CMD_DSHEND;
                    n_state = r_reins ? S_INSSCAN : S_DONE;
                end
            end
            S_INSSCAN: begin
                if (!i_status.ins_stop) w_cmd = CMD_SCAN_STEP;
                else begin
                    w_cmd = CMD_PTRSET; n_state = S_INSSHIFT;
                end
            end
            S_INSSHIFT: begin
                if (!i_status.shift_done) w_cmd = CMD_INSSHIFT;
                else begin
                    w_cmd = CMD_INSPUT; n_state = S_DONE;
                end
            end
            S_DONE: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_event <= EV_NONE; r_reins <= 1'b0;
        end else begin
            r_state <= n_state; r_event <= n_event; r_reins <= n_reins;
        end
        if (r_state == S_IDLE && i_in_valid) r_req <= i_req;
    end
endmodule

/* hw/rtl/two_level_sjf_rr_scheduler.sv */
// Top level of the two-level scheduler: channels, quantum register, controller
// and datapath. Depends on tlss_pkg, the channel interfaces, tlss_ctrl and tlss_datapath.
//
//  channel | dir | payload
//  i_in    | in  | op, priority_req, budget_ticks
//  o_out   | out | event_res, created_id, running_id, running_valid
//  i_cfg   | in  | slice length
//
// A request walks the controller states from acceptance to the result register, and
// the controller returns to idle before the next request is accepted; the free-slot
// scan, the sorted-list search and the list shifts walk one entry per cycle.
// Reset is synchronous and clears all control state. A held result stalls only
// the S_DONE state of the next request.
module two_level_sjf_rr_scheduler #(
    parameter int MAX_THREADS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlss_in_if.sink       i_in,
    tlss_out_if.source    o_out,
    tlss_cfg_if.sink      i_cfg
);
    import tlss_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);

    logic [7:0]    r_quantum;
    t_in_req       w_req;
    t_cmd          w_cmd;
    t_status       w_status;
    logic [IW-1:0] w_created, w_cur;
    logic          w_cur_valid, w_done;
    t_event        w_event;
    logic          r_out_valid;
    t_out_req      r_out;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_quantum <= 8'(QUANTUM_RESET);
        else if (i_cfg.valid) r_quantum <= i_cfg.data;
    end

    tlss_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_in.valid), .o_in_ready (i_in.ready), .i_req (i_in.data),
        .o_req (w_req), .i_status (w_status), .o_cmd (w_cmd),
        .o_done (w_done), .o_event (w_event), .i_out_free (!r_out_valid || o_out.ready)
    );

    tlss_datapath #(.MAX_THREADS(MAX_THREADS)) u_dp (
        .i_clk, .i_rst_n, .i_quantum (r_quantum), .i_req (w_req), .i_cmd (w_cmd),
        .o_status (w_status), .o_created (w_created), .o_cur (w_cur),
        .o_cur_valid (w_cur_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_done) r_out_valid <= 1'b1;
        else if (o_out.ready) r_out_valid <= 1'b0;
        if (w_done) begin
            r_out.event_res     <= w_event;
            r_out.created_id    <= (w_event == EV_CREATED) ? 4'(w_created) : 4'd0;
            r_out.running_id    <= w_cur_valid ? 4'(w_cur) : 4'd0;
            r_out.running_valid <= w_cur_valid;
        end
    end
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data));
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.data.running_valid |-> o_out.data.running_id == 4'd0);
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.event_res <= EV_FINISHED);
    a_created_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.event_res != EV_CREATED |->
        o_out.data.created_id == 4'd0);
endmodule

/* tb/sv/two_level_sjf_rr_scheduler_tb.sv */
// Testbench for the two-level scheduler: drives ticks, creates, exits and unused
// opcodes on the request channel, predicts each result and checks it field by field.
// Depends on tlss_pkg, the channel interfaces and two_level_sjf_rr_scheduler.
`timescale 1ns / 100ps

module two_level_sjf_rr_scheduler_tb;
    import tlss_pkg::*;

    localparam int NSLOT = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlss_in_if  in_ch();
    tlss_out_if out_ch();
    tlss_cfg_if cfg_ch();

    two_level_sjf_rr_scheduler #(.MAX_THREADS(NSLOT)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler state mirror
    logic [7:0]         quantum;
    logic               busy [NSLOT];
    logic               hi [NSLOT];
    int                 remain [NSLOT];
    logic [3:0]         sjf_list [$];
    logic [3:0]         rr_ring [$];
    logic [3:0]         cur_slot;
    logic               cur_valid;
    logic [7:0]         slice;
    t_out_req           expected_q [$];
    int                 fail_cnt = 0;
    int                 stall_pct = 20;

    function automatic int rand_gap();
        if ($urandom_range(99) < 90) return $urandom_range(2);
        return $urandom_range(30, 8);
    endfunction

    function automatic void sjf_insert(logic [3:0] s);
        int pos;
        pos = 0;
        while (pos < sjf_list.size() && remain[sjf_list[pos]] <= remain[s]) pos++;
        sjf_list.insert(pos, s);
    endfunction

    function automatic void dispatch_next();
        if (sjf_list.size() > 0) begin
            cur_slot = sjf_list.pop_front();
            cur_valid = 1'b1;
        end else if (rr_ring.size() > 0) begin
            cur_slot = rr_ring.pop_front();
            cur_valid = 1'b1;
        end else begin
            cur_slot = '0;
            cur_valid = 1'b0;
        end
        slice = quantum;
    endfunction

    function automatic t_event tick_sched();
        logic [3:0] c;
        if (!cur_valid) begin
            dispatch_next();
            return EV_NONE;
        end
        c = cur_slot;
        remain[c] -= 1;
        if (slice > 0) slice--;
        if (remain[c] < 0) begin
            busy[c] = 1'b0;
            dispatch_next();
            return EV_EJECTED;
        end
        if (hi[c]) begin
            if (sjf_list.size() > 0 && remain[sjf_list[0]] < remain[c]) begin
                dispatch_next();
                sjf_insert(c);
                return EV_PREEMPT;
            end
            return EV_NONE;
        end
        if (sjf_list.size() > 0 || slice == 0) begin
            rr_ring.push_back(c);
            dispatch_next();
            return EV_PREEMPT;
        end
        return EV_NONE;
    endfunction

    function automatic t_out_req predict_step(t_in_req r);
        t_out_req o;
        int i;
        o = '0;
        o.event_res = EV_NONE;
        if (r.op == OP_TICK) begin
            o.event_res = tick_sched();
        end else if (r.op == OP_CREATE) begin
            for (i = 0; i < NSLOT; i++) if (!busy[i]) break;
            if (i >= NSLOT) begin
                o.event_res = EV_REFUSED;
            end else begin
                busy[i] = 1'b1;
                hi[i] = r.priority_req;
                remain[i] = r.budget_ticks;
                if (r.priority_req) sjf_insert(4'(i));
                else rr_ring.push_back(4'(i));
                o.created_id = 4'(i);
                o.event_res = EV_CREATED;
            end
        end else if (r.op == OP_EXIT) begin
            if (cur_valid) begin
                busy[cur_slot] = 1'b0;
                dispatch_next();
                o.event_res = EV_FINISHED;
            end
        end
        o.running_id = cur_valid ? cur_slot : 4'd0;
        o.running_valid = cur_valid;
        return o;
    endfunction

    task automatic send_req(logic [1:0] op, logic pri, logic [15:0] budget);
        t_in_req r;
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r.op = op;
        r.priority_req = pri;
        r.budget_ticks = budget;
        in_ch.valid <= 1'b1;
        in_ch.data <= r;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_q.push_back(predict_step(r));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (3 * NSLOT + 10) @(posedge i_clk);
    endtask

    task automatic write_quantum(logic [7:0] q);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= q;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        quantum = q;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("unexpected result %h", out_ch.data);
                end else if (out_ch.data !== expected_q[0]) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"mismatch: exp ev=%0d cr=%0d run=%0d v=%0d",
                                  " got ev=%0d cr=%0d run=%0d v=%0d"},
                            expected_q[0].event_res, expected_q[0].created_id,
                            expected_q[0].running_id, expected_q[0].running_valid,
                            out_ch.data.event_res, out_ch.data.created_id,
                            out_ch.data.running_id, out_ch.data.running_valid);
                    void'(expected_q.pop_front());
                end else begin
                    void'(expected_q.pop_front());
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic test_directed();
        int i;
        send_req(OP_EXIT, 1'b0, 16'd0);
        send_req(OP_TICK, 1'b0, 16'd0);
        send_req(OP_UNUSED, 1'b1, 16'hFFFF);
        send_req(OP_CREATE, 1'b0, 16'd0);
        send_req(OP_CREATE, 1'b1, 16'hFFFF);
        send_req(OP_CREATE, 1'b1, 16'd2);
        send_req(OP_CREATE, 1'b1, 16'd2);
        for (i = 0; i < 14; i++) send_req(OP_TICK, 1'b0, 16'd0);
        for (i = 0; i < 3; i++) send_req(OP_EXIT, 1'b0, 16'd0);
    endtask

    task automatic test_full();
        int i;
        for (i = 0; i < 18; i++) send_req(OP_CREATE, i[0], 16'($urandom_range(6)));
        for (i = 0; i < 60; i++) send_req(OP_TICK, 1'b0, 16'd0);
        for (i = 0; i < 20; i++) send_req(OP_EXIT, 1'b0, 16'd0);
    endtask

    task automatic test_random(int n);
        int i, k;
        logic [15:0] b;
        for (i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 30) begin
                b = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
                send_req(OP_CREATE, 1'($urandom), b);
            end else if (k < 85) begin
                send_req(OP_TICK, 1'($urandom), 16'($urandom));
            end else if (k < 97) begin
                send_req(OP_EXIT, 1'($urandom), 16'($urandom));
            end else begin
                send_req(OP_UNUSED, 1'($urandom), 16'($urandom));
            end
            if (i % 200 == 100) stall_pct = (stall_pct == 0) ? 30 : 0;
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        quantum = QUANTUM_RESET;
        cur_slot = '0;
        cur_valid = 1'b0;
        slice = '0;
        for (int i = 0; i < NSLOT; i++) begin
            busy[i] = 1'b0;
            hi[i] = 1'b0;
            remain[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_quantum(8'd1);
        test_full();
        write_quantum(8'd0);
        test_random(300);
        write_quantum(8'd255);
        test_random(300);
        write_quantum(8'd3);
        test_random(400);
        write_quantum(8'($urandom_range(255)));
        test_random(300);
        drain();
        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("** two_level_sjf_rr_scheduler: PASSED **");
        end else begin
            $display("** two_level_sjf_rr_scheduler: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("** two_level_sjf_rr_scheduler: FAILED **");
        $finish;
    end

endmodule
